### hw/rtl/rtdc_pkg.sv
`default_nettype none
package rtdc_pkg;

	localparam int CODE_W  = 15;
	localparam int REF_W   = 21;
	localparam int R0_W    = 18;
	localparam int PROD_W  = CODE_W + REF_W;
	localparam int RES_W   = PROD_W - 15;
	localparam int NUM_W   = 62;
	localparam int RAD_W   = 64;
	localparam int ROOT_W  = RAD_W / 2;
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DATA_W = REF_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_REF = 8'd0,
		REG_NOM = 8'd1
	} cfg_reg_t;

	localparam logic [REF_W-1:0]  REF_RESET = 21'd110080;
	localparam logic [R0_W-1:0]   NOM_RESET = 18'd25600;

	localparam logic [PROD_W-1:0] OPEN_LIMIT  = 36'd200 << 23;
	localparam logic [PROD_W-1:0] SHORT_LIMIT = 36'd20 << 23;
	localparam logic [PROD_W-1:0] ROUND_HALF  = 36'd1 << 14;

	// Callendar-Van Dusen terms, scaled by 2e9
	localparam logic [63:0] CVD_A   = 64'd7816600;
	localparam logic [63:0] CVD_A2  = CVD_A * CVD_A;
	localparam logic [43:0] CVD_4B  = 44'd9240000000000;
	localparam logic [21:0] CVD_4B_LO = CVD_4B[21:0];
	localparam logic [21:0] CVD_4B_HI = CVD_4B[43:22];
	localparam logic signed [33:0] CVD_A256 = 34'sd2001049600;

	localparam logic [15:0] CVD_DIV   = 16'd59136;
	localparam logic [36:0] CVD_HALF  = 37'd29568;
	localparam logic signed [37:0] LIM_LO = -38'sd325248000;
	localparam logic signed [37:0] LIM_HI = 38'sd739200000;
	localparam logic [36:0] SAT_X     = 37'd1774139136;
	localparam logic [30:0] RECIP     = 31'((64'd1 << 46) / 64'd59136);
	localparam logic [14:0] CENTI_MAX = 15'd30000;

	typedef struct packed {
		logic       open;
		logic       shrt;
		logic       clr;
		logic [7:0] status;
	} side_t;

	typedef struct packed {
		side_t side;
		logic  le;
	} div_side_t;

endpackage
`default_nettype wire

### hw/rtl/rtdc_div.sv
`default_nettype none
// Restoring divider, one quotient bit per stage.
module rtdc_div #(
	parameter int NUM_W = rtdc_pkg::NUM_W,
	parameter int DEN_W = rtdc_pkg::R0_W
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_vld,
	input  wire logic [NUM_W-1:0]     numer,
	input  wire logic [DEN_W-1:0]     denom,
	input  wire rtdc_pkg::div_side_t  in_side,
	output logic                      out_vld,
	output logic [NUM_W-1:0]          quot,
	output rtdc_pkg::div_side_t       out_side
);

	logic                 vld_s  [NUM_W];
	logic [DEN_W-1:0]     rem_s  [NUM_W];
	logic [NUM_W-1:0]     nq_s   [NUM_W];
	logic [DEN_W-1:0]     den_s  [NUM_W];
	rtdc_pkg::div_side_t  side_s [NUM_W];

	for (genvar g = 0; g < NUM_W; g++) begin : g_stage
		logic                vld_p;
		logic [DEN_W-1:0]    rem_p;
		logic [NUM_W-1:0]    nq_p;
		logic [DEN_W-1:0]    den_p;
		rtdc_pkg::div_side_t side_p;
		logic [DEN_W:0]      trial;
		logic                ge;

		if (g == 0) begin : g_first
			assign vld_p  = in_vld;
			assign rem_p  = '0;
			assign nq_p   = numer;
			assign den_p  = denom;
			assign side_p = in_side;
		end else begin : g_next
			assign vld_p  = vld_s[g-1];
			assign rem_p  = rem_s[g-1];
			assign nq_p   = nq_s[g-1];
			assign den_p  = den_s[g-1];
			assign side_p = side_s[g-1];
		end

		assign trial = {rem_p, nq_p[NUM_W-1]};
		assign ge    = trial >= {1'b0, den_p};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else begin
				vld_s[g] <= vld_p;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[g]  <= ge ? DEN_W'(trial - {1'b0, den_p}) : DEN_W'(trial);
			nq_s[g]   <= {nq_p[NUM_W-2:0], ge};
			den_s[g]  <= den_p;
			side_s[g] <= side_p;
		end
	end

	assign out_vld  = vld_s[NUM_W-1];
	assign quot     = nq_s[NUM_W-1];
	assign out_side = side_s[NUM_W-1];

endmodule
`default_nettype wire

### hw/rtl/rtdc_sqrt.sv
`default_nettype none
// Digit-by-digit integer square root, one root bit per stage.
module rtdc_sqrt #(
	parameter int RAD_W = rtdc_pkg::RAD_W
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_vld,
	input  wire logic [RAD_W-1:0]  rad,
	input  wire rtdc_pkg::side_t   in_side,
	output logic                   out_vld,
	output logic [RAD_W/2-1:0]     root,
	output rtdc_pkg::side_t        out_side
);

	localparam int ROOT_W = RAD_W / 2;
	localparam int REM_W  = ROOT_W + 2;

	logic               vld_s  [ROOT_W];
	logic [REM_W-1:0]   rem_s  [ROOT_W];
	logic [ROOT_W-1:0]  root_s [ROOT_W];
	logic [RAD_W-1:0]   rad_s  [ROOT_W];
	rtdc_pkg::side_t    side_s [ROOT_W];

	for (genvar g = 0; g < ROOT_W; g++) begin : g_stage
		logic              vld_p;
		logic [REM_W-1:0]  rem_p;
		logic [ROOT_W-1:0] root_p;
		logic [RAD_W-1:0]  rad_p;
		rtdc_pkg::side_t   side_p;
		logic [REM_W+1:0]  cur;
		logic [REM_W+1:0]  trial;
		logic              ge;

		if (g == 0) begin : g_first
			assign vld_p  = in_vld;
			assign rem_p  = '0;
			assign root_p = '0;
			assign rad_p  = rad;
			assign side_p = in_side;
		end else begin : g_next
			assign vld_p  = vld_s[g-1];
			assign rem_p  = rem_s[g-1];
			assign root_p = root_s[g-1];
			assign rad_p  = rad_s[g-1];
			assign side_p = side_s[g-1];
		end

		assign cur   = {rem_p, rad_p[RAD_W-1:RAD_W-2]};
		assign trial = {2'b00, root_p, 2'b01};
		assign ge    = cur >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else begin
				vld_s[g] <= vld_p;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[g]  <= ge ? REM_W'(cur - trial) : REM_W'(cur);
			root_s[g] <= {root_p[ROOT_W-2:0], ge};
			rad_s[g]  <= {rad_p[RAD_W-3:0], 2'b00};
			side_s[g] <= side_p;
		end
	end

	assign out_vld  = vld_s[ROOT_W-1];
	assign root     = root_s[ROOT_W-1];
	assign out_side = side_s[ROOT_W-1];

endmodule
`default_nettype wire

### hw/rtl/rtdc_post.sv
`default_nettype none
// Root to centidegrees: range test, rounding divide by constant, saturation.
module rtdc_post (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_vld,
	input  wire logic [rtdc_pkg::ROOT_W-1:0]   root,
	input  wire rtdc_pkg::side_t               in_side,
	output logic                               done,
	output logic signed [15:0]                 temperature_centi,
	output logic                               probe_open,
	output logic                               probe_short,
	output logic                               out_of_range,
	output logic                               clear_request,
	output logic [7:0]                         status_echo
);

	logic signed [33:0] num;
	logic signed [37:0] num10;
	logic               neg;
	logic [36:0]        mag;
	logic [36:0]        xr;

	logic               vld_s1, vld_s2, vld_s3;
	rtdc_pkg::side_t    side_s1, side_s2, side_s3;
	logic [30:0]        x_s1, x_s2, x_s3;
	logic               sat_s1, sat_s2, sat_s3;
	logic               neg_s1, neg_s2, neg_s3;
	logic               oor_s1, oor_s2, oor_s3;
	logic [14:0]        qe_s2, qe_s3;
	logic [30:0]        qd_s3;

	logic [61:0]        recip_prod;
	logic [30:0]        rem;
	logic [14:0]        q;
	logic [14:0]        q_sat;
	logic               fault;

	assign num   = rtdc_pkg::CVD_A256 - $signed({2'b00, root});
	assign num10 = ($signed(38'(num)) <<< 3) + ($signed(38'(num)) <<< 1);
	assign neg   = num10 < 0;
	assign mag   = neg ? 37'(-num10) : 37'(num10);
	assign xr    = mag + rtdc_pkg::CVD_HALF;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			done   <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			done   <= vld_s3;
		end
	end

	assign recip_prod = 62'(x_s1) * 62'(rtdc_pkg::RECIP);

	always_ff @(posedge clk) begin
		side_s1 <= in_side;
		x_s1    <= xr[30:0];
		sat_s1  <= xr >= rtdc_pkg::SAT_X;
		neg_s1  <= neg;
		oor_s1  <= (num10 < rtdc_pkg::LIM_LO) || (num10 > rtdc_pkg::LIM_HI);

		side_s2 <= side_s1;
		x_s2    <= x_s1;
		sat_s2  <= sat_s1;
		neg_s2  <= neg_s1;
		oor_s2  <= oor_s1;
		qe_s2   <= recip_prod[60:46];

		side_s3 <= side_s2;
		x_s3    <= x_s2;
		sat_s3  <= sat_s2;
		neg_s3  <= neg_s2;
		oor_s3  <= oor_s2;
		qe_s3   <= qe_s2;
		qd_s3   <= 31'(qe_s2) * 31'(rtdc_pkg::CVD_DIV);
	end

	// estimate is low by at most one
	assign rem   = x_s3 - qd_s3;
	assign q     = (rem >= 31'(rtdc_pkg::CVD_DIV)) ? qe_s3 + 15'd1 : qe_s3;
	assign q_sat = sat_s3 ? rtdc_pkg::CENTI_MAX : q;
	assign fault = side_s3.open || side_s3.shrt;

	always_ff @(posedge clk) begin
		if (fault) begin
			temperature_centi <= '0;
		end else if (neg_s3) begin
			temperature_centi <= -$signed({1'b0, q_sat});
		end else begin
			temperature_centi <= $signed({1'b0, q_sat});
		end
		out_of_range  <= oor_s3 && !fault;
		probe_open    <= side_s3.open;
		probe_short   <= side_s3.shrt;
		clear_request <= side_s3.clr;
		status_echo   <= side_s3.status;
	end

endmodule
`default_nettype wire

### hw/rtl/rtd_code_to_temperature_core.sv
`default_nettype none
// RTD code to temperature converter.
//
// Command channel: a transaction is taken at each clock edge where start is
// high and busy is low. busy is always low: one sample may enter every cycle.
// rtd_word carries the 15-bit code in bits 15..1 and the converter fault
// flag in bit 0; fault_status is the converter's status byte.
//
// Result channel: done pulses for one cycle with the result fields valid.
// Throughput is one per cycle. The pipeline length is set by the
// 62-stage pipelined divider (4B*dR/R0) and the 32-stage pipelined square
// root. The receiver cannot stall; results are delivered in order.
//
// Configuration: cfg_valid/cfg_ready write channel, cfg_ready always high.
// Index 0 is the reference resistor, index 1 the nominal (0 degC) sensor
// resistance, both ohms with 8 fraction bits. Other indices are ignored.
// Write only while no transaction is in flight.
//
// Reset clears the pipeline valid bits and loads 430 ohm / 100 ohm.
module rtd_code_to_temperature_core (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic [15:0]                         rtd_word,
	input  wire logic [7:0]                          fault_status,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [rtdc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [rtdc_pkg::CFG_DATA_W-1:0]     cfg_data,
	output logic                                     done,
	output logic signed [15:0]                       temperature_centi,
	output logic                                     probe_open,
	output logic                                     probe_short,
	output logic                                     out_of_range,
	output logic                                     clear_request,
	output logic [7:0]                               status_echo
);

	logic [rtdc_pkg::REF_W-1:0] ref_q;
	logic [rtdc_pkg::R0_W-1:0]  nom_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q <= rtdc_pkg::REF_RESET;
			nom_q <= rtdc_pkg::NOM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (rtdc_pkg::cfg_reg_t'(cfg_index))
				rtdc_pkg::REG_REF: ref_q <= cfg_data[rtdc_pkg::REF_W-1:0];
				rtdc_pkg::REG_NOM: nom_q <= cfg_data[rtdc_pkg::R0_W-1:0];
				default: ;
			endcase
		end
	end

	// Stage 1: code times reference resistor (ohms, 23 fraction bits)
	logic                        vld_s1;
	logic [rtdc_pkg::PROD_W-1:0] prod_s1;
	logic                        flag_s1;
	logic [7:0]                  status_s1;

	// Stage 2: probe checks, rounded resistance, |R0 - R|
	logic                        vld_s2;
	rtdc_pkg::div_side_t         dside_s2;
	logic [rtdc_pkg::R0_W-1:0]   diff_s2;
	logic [rtdc_pkg::R0_W-1:0]   r0_s2;

	// Stage 3: 4B * diff as two partial products
	logic                        vld_s3;
	rtdc_pkg::div_side_t         dside_s3;
	logic [39:0]                 plo_s3;
	logic [39:0]                 phi_s3;
	logic [rtdc_pkg::R0_W-1:0]   r0_s3;

	// Stage 4: dividend assembled
	logic                        vld_s4;
	rtdc_pkg::div_side_t         dside_s4;
	logic [rtdc_pkg::NUM_W-1:0]  numer_s4;
	logic [rtdc_pkg::R0_W-1:0]   r0_s4;

	// Stage 5: discriminant, pre-shifted for the root
	logic                        vld_s5;
	rtdc_pkg::side_t             side_s5;
	logic [rtdc_pkg::RAD_W-1:0]  rad_s5;

	logic                        open_c;
	logic                        shrt_c;
	logic [rtdc_pkg::RES_W-1:0]  res_c;
	logic [rtdc_pkg::R0_W-1:0]   r0_c;
	logic                        le_c;

	logic                        div_vld;
	logic [rtdc_pkg::NUM_W-1:0]  div_quot;
	rtdc_pkg::div_side_t         div_side;
	logic [63:0]                 disc_c;

	logic                        sq_vld;
	logic [rtdc_pkg::ROOT_W-1:0] sq_root;
	rtdc_pkg::side_t             sq_side;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= div_vld;
		end
	end

	assign open_c = flag_s1 || status_s1[2] || (prod_s1 > rtdc_pkg::OPEN_LIMIT);
	assign shrt_c = !open_c && (prod_s1 < rtdc_pkg::SHORT_LIMIT);
	assign res_c  = rtdc_pkg::RES_W'((prod_s1 + rtdc_pkg::ROUND_HALF) >> 15);
	assign r0_c   = (nom_q == '0) ? rtdc_pkg::R0_W'(1) : nom_q;
	assign le_c   = res_c <= rtdc_pkg::RES_W'(r0_c);

	// only a sensible value when no probe fault; result is zeroed otherwise
	always_ff @(posedge clk) begin
		prod_s1   <= rtdc_pkg::PROD_W'(rtd_word[15:1]) * rtdc_pkg::PROD_W'(ref_q);
		flag_s1   <= rtd_word[0];
		status_s1 <= fault_status;

		dside_s2.side.open   <= open_c;
		dside_s2.side.shrt   <= shrt_c;
		dside_s2.side.clr    <= flag_s1 || (status_s1 != 8'd0);
		dside_s2.side.status <= status_s1;
		dside_s2.le          <= le_c;
		diff_s2 <= le_c ? rtdc_pkg::R0_W'(rtdc_pkg::RES_W'(r0_c) - res_c)
				: rtdc_pkg::R0_W'(res_c - rtdc_pkg::RES_W'(r0_c));
		r0_s2   <= r0_c;

		dside_s3 <= dside_s2;
		plo_s3   <= 40'(diff_s2) * 40'(rtdc_pkg::CVD_4B_LO);
		phi_s3   <= 40'(diff_s2) * 40'(rtdc_pkg::CVD_4B_HI);
		r0_s3    <= r0_s2;

		dside_s4 <= dside_s3;
		numer_s4 <= rtdc_pkg::NUM_W'(plo_s3) + (rtdc_pkg::NUM_W'(phi_s3) << 22);
		r0_s4    <= r0_s3;

		side_s5 <= div_side.side;
		rad_s5  <= disc_c << 16;
	end

	rtdc_div #(
		.NUM_W (rtdc_pkg::NUM_W),
		.DEN_W (rtdc_pkg::R0_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s4),
		.numer    (numer_s4),
		.denom    (r0_s4),
		.in_side  (dside_s4),
		.out_vld  (div_vld),
		.quot     (div_quot),
		.out_side (div_side)
	);

	// Discriminant clamps at zero when R is far above R0
	always_comb begin
		if (div_side.le) begin
			disc_c = rtdc_pkg::CVD_A2 + 64'(div_quot);
		end else if (64'(div_quot) >= rtdc_pkg::CVD_A2) begin
			disc_c = '0;
		end else begin
			disc_c = rtdc_pkg::CVD_A2 - 64'(div_quot);
		end
	end

	rtdc_sqrt #(
		.RAD_W (rtdc_pkg::RAD_W)
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s5),
		.rad      (rad_s5),
		.in_side  (side_s5),
		.out_vld  (sq_vld),
		.root     (sq_root),
		.out_side (sq_side)
	);

	rtdc_post u_post (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_vld            (sq_vld),
		.root              (sq_root),
		.in_side           (sq_side),
		.done              (done),
		.temperature_centi (temperature_centi),
		.probe_open        (probe_open),
		.probe_short       (probe_short),
		.out_of_range      (out_of_range),
		.clear_request     (clear_request),
		.status_echo       (status_echo)
	);

	a_open_short_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(probe_open && probe_short))
		else $error("open and short both flagged");

	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (probe_open || probe_short)) |-> (temperature_centi == 16'sd0 && !out_of_range))
		else $error("probe fault result not cleared");

	a_sat_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (temperature_centi >= -16'sd30000 && temperature_centi <= 16'sd30000))
		else $error("temperature outside saturation limits");

	a_open_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status_echo[2]) |-> (probe_open && clear_request))
		else $error("voltage fault not reported");

endmodule
`default_nettype wire

### tb/rtd_temperature_checker.sv
`default_nettype none
module rtd_temperature_checker (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	input  wire logic                            busy,
	input  wire logic [15:0]                     rtd_word,
	input  wire logic [7:0]                      fault_status,
	input  wire logic                            cfg_valid,
	input  wire logic                            cfg_ready,
	input  wire logic [rtdc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [rtdc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                            done,
	input  wire logic signed [15:0]              temperature_centi,
	input  wire logic                            probe_open,
	input  wire logic                            probe_short,
	input  wire logic                            out_of_range,
	input  wire logic                            clear_request,
	input  wire logic [7:0]                      status_echo,
	output int                                   mismatches,
	output int                                   pending
);

	typedef struct packed {
		logic signed [15:0] centi;
		logic               open;
		logic               shrt;
		logic               oor;
		logic               clr;
		logic [7:0]         status;
	} reading_t;

	logic [rtdc_pkg::REF_W-1:0] ref_res;
	logic [rtdc_pkg::R0_W-1:0]  nom_res;
	reading_t                   readings_due[$];

	function automatic logic [63:0] root64(input logic [63:0] v);
		logic [63:0] root;
		logic [63:0] bitv;
		root = '0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= root + bitv) begin
				v = v - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return root;
	endfunction

	function automatic reading_t predict_reading(input logic [15:0] word, input logic [7:0] st);
		reading_t         rd;
		logic [63:0]      prod, r, r0, a2, disc, t, s, mag, q;
		logic signed [63:0] num, num10;
		logic             flag;
		flag = word[0];
		prod = 64'(word[15:1]) * 64'(ref_res);
		rd = '0;
		rd.open = flag || st[2] || prod > 64'(rtdc_pkg::OPEN_LIMIT);
		rd.shrt = !rd.open && prod < 64'(rtdc_pkg::SHORT_LIMIT);
		rd.clr = flag || st != 0;
		rd.status = st;
		if (!rd.open && !rd.shrt) begin
			r = (prod + (64'd1 << 14)) >> 15;
			r0 = (nom_res != 0) ? 64'(nom_res) : 64'd1;
			a2 = 64'd7816600 * 64'd7816600;
			if (r <= r0) begin
				disc = a2 + (64'd9240000000000 * (r0 - r)) / r0;
			end else begin
				t = (64'd9240000000000 * (r - r0)) / r0;
				disc = (t >= a2) ? 64'd0 : a2 - t;
			end
			s = root64(disc << 16);
			num = $signed(64'd2001049600) - $signed(s);
			num10 = num * 64'sd10;
			rd.oor = num10 < -64'sd325248000 || num10 > 64'sd739200000;
			mag = (num10 < 0) ? 64'(-num10) : 64'(num10);
			q = (mag + 64'd29568) / 64'd59136;
			if (q > 64'd30000)
				q = 64'd30000;
			rd.centi = (num10 < 0) ? -16'(q) : 16'(q);
		end
		return rd;
	endfunction

	assign pending = readings_due.size();

	always @(posedge clk or negedge arst_n) begin
		reading_t want;
		reading_t got;
		if (!arst_n) begin
			ref_res <= rtdc_pkg::REF_RESET;
			nom_res <= rtdc_pkg::NOM_RESET;
			readings_due.delete();
			mismatches <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == rtdc_pkg::REG_REF)
					ref_res <= cfg_data[rtdc_pkg::REF_W-1:0];
				else if (cfg_index == rtdc_pkg::REG_NOM)
					nom_res <= cfg_data[rtdc_pkg::R0_W-1:0];
			end
			if (start && !busy)
				readings_due.push_back(predict_reading(rtd_word, fault_status));
			if (done) begin
				got = '{temperature_centi, probe_open, probe_short, out_of_range,
					clear_request, status_echo};
				if (readings_due.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected result transaction: %p", got);
					mismatches <= mismatches + 1;
				end else begin
					want = readings_due.pop_front();
					if (want != got) begin
						if (mismatches < 10)
							$display("mismatch: expected %p, got %p", want, got);
						mismatches <= mismatches + 1;
					end
				end
			end
		end
	end
endmodule
`default_nettype wire

### tb/tb_rtd_code_to_temperature_core.sv
`default_nettype none
module tb_rtd_code_to_temperature_core;

	logic                            clk = 0;
	logic                            arst_n = 0;
	logic                            start = 0;
	logic [15:0]                     rtd_word = 0;
	logic [7:0]                      fault_status = 0;
	logic                            cfg_valid = 0;
	logic [rtdc_pkg::CFG_IDX_W-1:0]  cfg_index = 0;
	logic [rtdc_pkg::CFG_DATA_W-1:0] cfg_data = 0;
	wire                             busy, cfg_ready, done;
	wire signed [15:0]               temperature_centi;
	wire                             probe_open, probe_short, out_of_range, clear_request;
	wire [7:0]                       status_echo;
	int                              mismatches, pending;
	logic [rtdc_pkg::REF_W-1:0]      cur_ref;

	// free-running clock, 10 time units per period
	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	rtd_code_to_temperature_core dut (
		.clk, .arst_n, .start, .busy, .rtd_word, .fault_status,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .done,
		.temperature_centi, .probe_open, .probe_short, .out_of_range,
		.clear_request, .status_echo
	);

	rtd_temperature_checker chk (
		.clk, .arst_n, .start, .busy, .rtd_word, .fault_status,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .done,
		.temperature_centi, .probe_open, .probe_short, .out_of_range,
		.clear_request, .status_echo, .mismatches, .pending
	);

	// watchdog: far beyond the slowest legal run
	initial begin
		#20000000;
		$display("RESULT: ERROR");
		$finish;
	end

	// One sample transaction. Called at a falling edge; returns at a falling edge.
	// start stays high across back-to-back transactions (no low/high in one step).
	task automatic send_sample(input logic [15:0] word, input logic [7:0] st);
		int gap;
		gap = $urandom_range(0, 7);
		if ($urandom_range(0, 3) == 0)
			gap = 0;	// keep stretches of full-rate traffic
		if (gap > 0) begin
			start <= 0;
			repeat (gap) @(negedge clk);
		end
		start <= 1;
		rtd_word <= word;
		fault_status <= st;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	// Stop sending and wait until every pending result is back, plus pipeline depth.
	task automatic drain;
		start <= 0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (110) @(negedge clk);
	endtask

	// Register write; only issued while drained.
	task automatic write_reg(input logic [rtdc_pkg::CFG_IDX_W-1:0] idx,
			input logic [rtdc_pkg::CFG_DATA_W-1:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 0;
		if (idx == rtdc_pkg::REG_REF)
			cur_ref = val;
		@(negedge clk);
	endtask

	// Random code: half uniform, half aimed at the 15..205 ohm window for this reference.
	function automatic logic [15:0] random_word();
		logic [63:0] c;
		if ($urandom_range(0, 1) == 0) begin
			c = 64'($urandom_range(0, 32767));
		end else begin
			c = (64'($urandom_range(15 * 256, 205 * 256)) << 15) / 64'(cur_ref);
			if (c > 32767)
				c = 64'd32767;
		end
		return {c[14:0], 1'b0};
	endfunction

	task automatic random_phase(input int count);
		logic [15:0] w;
		logic [7:0]  st;
		for (int i = 0; i < count; i++) begin
			w = random_word();
			st = '0;
			// mostly clean samples; some with flag / status noise
			if ($urandom_range(0, 9) < 3) begin
				w[0] = 1'($urandom_range(0, 1));
				st = 8'($urandom_range(0, 255));
			end
			send_sample(w, st);
		end
	endtask

	initial begin
		cur_ref = rtdc_pkg::REF_RESET;
		repeat (10) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: extremes, flags, probe thresholds, range edges (430/100 ohm)
		send_sample(16'h0000, 8'h00);
		send_sample(16'hFFFE, 8'h00);
		send_sample(16'hFFFF, 8'hFF);
		send_sample(16'h0001, 8'h00);
		send_sample({15'd8000, 1'b0}, 8'h04);
		send_sample({15'd8000, 1'b0}, 8'h80);
		send_sample({15'd1524, 1'b0}, 8'h00);	// just short
		send_sample({15'd1525, 1'b0}, 8'h00);	// just not short
		send_sample({15'd15240, 1'b0}, 8'h00);	// just not open
		send_sample({15'd15241, 1'b0}, 8'h00);	// just open
		send_sample({15'd5965, 1'b0}, 8'h00);	// around -55 C
		send_sample({15'd5970, 1'b0}, 8'h00);
		send_sample({15'd7620, 1'b0}, 8'h00);	// about 0 C
		send_sample({15'd11270, 1'b0}, 8'h00);	// around 125 C
		send_sample({15'd11280, 1'b0}, 8'h00);
		drain();

		// tiny R0: discriminant goes negative, output saturates
		write_reg(rtdc_pkg::REG_NOM, 21'd256);
		send_sample({15'd7620, 1'b0}, 8'h00);
		send_sample({15'd3000, 1'b0}, 8'h00);
		drain();
		// R0 of zero, plus writes to unknown indices that must be ignored
		write_reg(rtdc_pkg::REG_NOM, 21'd0);
		write_reg(8'd5, 21'h1FFFFF);
		write_reg(8'hFF, 21'h1FFFFF);
		send_sample({15'd7620, 1'b0}, 8'h00);
		drain();

		// random phases over several settings, extremes included
		write_reg(rtdc_pkg::REG_REF, rtdc_pkg::REF_RESET);
		write_reg(rtdc_pkg::REG_NOM, 21'(rtdc_pkg::NOM_RESET));
		random_phase(160);
		drain();
		write_reg(rtdc_pkg::REG_REF, 21'h1FFFFF);
		write_reg(rtdc_pkg::REG_NOM, 21'h3FFFF);
		random_phase(130);
		drain();
		write_reg(rtdc_pkg::REG_REF, 21'd256);
		write_reg(rtdc_pkg::REG_NOM, 21'd256);
		random_phase(130);
		drain();
		write_reg(rtdc_pkg::REG_REF, 21'd1024000);	// 4000 ohm reference
		write_reg(rtdc_pkg::REG_NOM, 21'd256000);	// 1000 ohm sensor
		random_phase(130);
		drain();
		for (int p = 0; p < 2; p++) begin
			write_reg(rtdc_pkg::REG_REF, 21'($urandom_range(256, 2097151)));
			write_reg(rtdc_pkg::REG_NOM, 21'($urandom_range(256, 262143)));
			random_phase(150);
			drain();
		end

		if (mismatches == 0 && pending == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule
`default_nettype wire
